### rtl/fifo_resource_pool_allocator_unit_assert.svh
// Assertion macros for the resource pool allocator.
`ifndef FIFO_RESOURCE_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FIFO_RESOURCE_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FPRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fpra_pkg.sv
// Types and constants shared by the resource pool allocator.
`default_nettype none
package fpra_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int WAIT_WIDTH  = 5;
    localparam int ID_WIDTH    = 8;
    localparam int GRANT_CNT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam logic [2:0] REQ_RESERVE   = 3'd0;
    localparam logic [2:0] REQ_UNRESERVE = 3'd1;
    localparam logic [2:0] REQ_CAP_INC   = 3'd2;
    localparam logic [2:0] REQ_IDLE      = 3'd3;
    localparam logic [2:0] REQ_NON_IDLE  = 3'd4;

    typedef enum logic [2:0] {
        STAT_GRANTED   = 3'd0,
        STAT_QUEUED    = 3'd1,
        STAT_OK        = 3'd2,
        STAT_OVER_CAP  = 3'd3,
        STAT_UNDERFLOW = 3'd4,
        STAT_BAD_AMT   = 3'd5,
        STAT_Q_FULL    = 3'd6,
        STAT_OVERFLOW  = 3'd7
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_WAKE = 1'b1
    } state_t;

    // Capacity and free units as seen from the current counts.
    typedef struct packed {
        count_t cap;
        count_t avail;
    } pool_view_t;

    typedef struct packed {
        status_t               status;
        logic                  grant_valid;
        logic [ID_WIDTH-1:0]   granted_id;
        count_t                granted_amount;
        count_t                total_capacity;
        count_t                reserved_count;
        count_t                busy_count;
        logic [WAIT_WIDTH-1:0] waiting_count;
        logic                  last;
    } result_t;

endpackage
`default_nettype wire

### rtl/fpra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### rtl/fpra_avail.sv
// Pool capacity (saturating) and free-unit computation.
`default_nettype none
module fpra_avail
    import fpra_pkg::*;
(
    input  wire count_t     base_cap,
    input  wire count_t     added_cap,
    input  wire count_t     reserved,
    output pool_view_t      view
);

    logic [COUNT_WIDTH:0] cap_sum;

    always_comb
    begin
        cap_sum    = {1'b0, base_cap} + {1'b0, added_cap};
        view.cap   = cap_sum[COUNT_WIDTH] ? COUNT_MAX : cap_sum[COUNT_WIDTH-1:0];
        view.avail = (view.cap > reserved) ? (view.cap - reserved) : '0;
    end

endmodule
`default_nettype wire

### rtl/fifo_resource_pool_allocator_unit.sv
// Top level of the FIFO-ordered counting resource pool allocator.
//
// Requests enter on start/busy: one is taken at a clock edge where start is high
// and busy is low, with req_type, amount and requester_id alongside. Results
// leave on result_valid, one cycle each, with last marking the final result of
// a request; the receiver has no way to hold them off.
// Reserve, idle/non-idle notices and rejected requests give one result in the cycle
// after acceptance; busy stays low, so a new request can be taken every cycle.
// Unreserve and capacity increase walk the waiter queue held in RAM: one head is
// examined per cycle, and each grant's result passes through a pending register
// before the output register; busy is high for that walk. The queue walk is
// bound by the single RAM read port, one head per cycle.
// Write base capacity through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
// Reset clears counts, pointers and the sequencer; queue RAM contents are left
// as they are and only read once written.
`default_nettype none
`include "fifo_resource_pool_allocator_unit_assert.svh"
module fifo_resource_pool_allocator_unit
    import fpra_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [COUNT_WIDTH-1:0] cfg_wr_data,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [2:0]             req_type,
    input  wire logic [COUNT_WIDTH-1:0] amount,
    input  wire logic [ID_WIDTH-1:0]    requester_id,
    output logic                        result_valid,
    output logic [2:0]                  status,
    output logic                        grant_valid,
    output logic [ID_WIDTH-1:0]         granted_id,
    output logic [COUNT_WIDTH-1:0]      granted_amount,
    output logic [COUNT_WIDTH-1:0]      total_capacity,
    output logic [COUNT_WIDTH-1:0]      reserved_count,
    output logic [COUNT_WIDTH-1:0]      busy_count,
    output logic [WAIT_WIDTH-1:0]       waiting_count,
    output logic                        last
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W  = ID_WIDTH + COUNT_WIDTH;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    state_t               state_reg, state_next;
    count_t               base_reg;
    count_t               added_reg, added_next;
    count_t               reserved_reg, reserved_next;
    count_t               ubusy_reg, ubusy_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [GRANT_CNT_W-1:0] grants_reg, grants_next;
    logic                 pend_valid_reg, pend_valid_next;
    result_t              pend_reg, pend_next;
    result_t              out_reg;
    logic                 out_valid_reg;

    pool_view_t           view;
    logic                 accept;
    logic                 to_wake;
    logic                 fits;
    logic                 emit;
    result_t              emit_res;
    logic                 q_wr_en;
    logic [ENT_W-1:0]     q_rd_data;
    logic [ID_WIDTH-1:0]  head_id;
    count_t               head_amt;
    logic [COUNT_WIDTH+1:0] cap_check;

    assign accept   = start && (state_reg == ST_IDLE);
    assign head_id  = q_rd_data[ENT_W-1:COUNT_WIDTH];
    assign head_amt = q_rd_data[COUNT_WIDTH-1:0];

    fpra_avail u_avail (
        .base_cap  (base_reg),
        .added_cap (added_reg),
        .reserved  (reserved_reg),
        .view      (view)
    );

    // Read address follows the next head so the registered read data holds the head entry once head_reg takes it.
    fpra_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (tail_reg),
        .wr_data ({requester_id, amount}),
        .rd_addr (head_next),
        .rd_data (q_rd_data)
    );

    assign fits = (count_reg != '0)
               && (grants_reg < GRANT_CNT_W'(MAX_RESULTS))
               && (view.avail >= head_amt);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && to_wake)
                begin
                    state_next = ST_WAKE;
                end
            end
            ST_WAKE:
            begin
                if (!fits)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result selection
    always_comb
    begin
        added_next      = added_reg;
        reserved_next   = reserved_reg;
        ubusy_next      = ubusy_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        grants_next     = grants_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        to_wake         = 1'b0;
        q_wr_en         = 1'b0;
        emit            = 1'b0;
        cap_check       = {2'b00, base_reg} + {2'b00, added_reg} + {2'b00, amount};

        emit_res                = '0;
        emit_res.status         = STAT_OK;
        emit_res.last           = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    emit = 1'b1;
                    unique case (req_type)
                        REQ_RESERVE:
                        begin
                            if (amount > view.cap)
                            begin
                                emit_res.status = STAT_OVER_CAP;
                            end
                            else if ((count_reg == '0) && (view.avail >= amount))
                            begin
                                reserved_next           = reserved_reg + amount;
                                emit_res.status         = STAT_GRANTED;
                                emit_res.grant_valid    = 1'b1;
                                emit_res.granted_id     = requester_id;
                                emit_res.granted_amount = amount;
                            end
                            else if (count_reg == CNT_FULL)
                            begin
                                emit_res.status = STAT_Q_FULL;
                            end
                            else
                            begin
                                q_wr_en         = 1'b1;
                                tail_next       = (tail_reg == PTR_LAST) ? '0
                                                : tail_reg + 1'b1;
                                count_next      = count_reg + 1'b1;
                                emit_res.status = STAT_QUEUED;
                            end
                        end
                        REQ_UNRESERVE:
                        begin
                            if (amount > reserved_reg)
                            begin
                                emit_res.status = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                reserved_next = reserved_reg - amount;
                                to_wake       = 1'b1;
                                emit          = 1'b0;
                            end
                        end
                        REQ_CAP_INC:
                        begin
                            if (amount == '0)
                            begin
                                emit_res.status = STAT_BAD_AMT;
                            end
                            else if (cap_check > (COUNT_WIDTH+2)'(COUNT_MAX))
                            begin
                                emit_res.status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                added_next = added_reg + amount;
                                to_wake    = 1'b1;
                                emit       = 1'b0;
                            end
                        end
                        REQ_IDLE:
                        begin
                            if (ubusy_reg == '0)
                            begin
                                emit_res.status = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                ubusy_next = ubusy_reg - 1'b1;
                            end
                        end
                        REQ_NON_IDLE:
                        begin
                            if (ubusy_reg >= reserved_reg)
                            begin
                                emit_res.status = STAT_OVER_CAP;
                            end
                            else
                            begin
                                ubusy_next = ubusy_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            emit_res.status = STAT_BAD_AMT;
                        end
                    endcase
                    grants_next     = '0;
                    pend_valid_next = 1'b0;
                end
                emit_res.total_capacity = view.cap;
                emit_res.reserved_count = reserved_next;
                emit_res.busy_count     = ubusy_next;
                emit_res.waiting_count  = WAIT_WIDTH'(count_next);
            end
            ST_WAKE:
            begin
                if (fits)
                begin
                    reserved_next = reserved_reg + head_amt;
                    head_next     = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                    count_next    = count_reg - 1'b1;
                    grants_next   = grants_reg + 1'b1;

                    // Previous grant goes out now; this one waits to learn if it is final.
                    emit          = pend_valid_reg;
                    emit_res      = pend_reg;
                    emit_res.last = 1'b0;

                    pend_valid_next          = 1'b1;
                    pend_next.status         = STAT_GRANTED;
                    pend_next.grant_valid    = 1'b1;
                    pend_next.granted_id     = head_id;
                    pend_next.granted_amount = head_amt;
                    pend_next.total_capacity = view.cap;
                    pend_next.reserved_count = reserved_next;
                    pend_next.busy_count     = ubusy_reg;
                    pend_next.waiting_count  = WAIT_WIDTH'(count_next);
                    pend_next.last           = 1'b0;
                end
                else
                begin
                    emit            = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        emit_res = pend_reg;
                    end
                    else
                    begin
                        emit_res.total_capacity = view.cap;
                        emit_res.reserved_count = reserved_reg;
                        emit_res.busy_count     = ubusy_reg;
                        emit_res.waiting_count  = WAIT_WIDTH'(count_reg);
                    end
                    emit_res.last = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_reg       <= '0;
            added_reg      <= '0;
            reserved_reg   <= '0;
            ubusy_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            grants_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            added_reg      <= added_next;
            reserved_reg   <= reserved_next;
            ubusy_reg      <= ubusy_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            grants_reg     <= grants_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (emit)
        begin
            out_reg <= emit_res;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign result_valid   = out_valid_reg;
    assign status         = out_reg.status;
    assign grant_valid    = out_reg.grant_valid;
    assign granted_id     = out_reg.granted_id;
    assign granted_amount = out_reg.granted_amount;
    assign total_capacity = out_reg.total_capacity;
    assign reserved_count = out_reg.reserved_count;
    assign busy_count     = out_reg.busy_count;
    assign waiting_count  = out_reg.waiting_count;
    assign last           = out_reg.last;

    `FPRA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_FULL, "queue count above depth")
    `FPRA_ASSERT_NOW(a_grant_bound, 1'b1, grants_reg <= GRANT_CNT_W'(MAX_RESULTS), "too many grants")
    `FPRA_ASSERT_NOW(a_last_idle, result_valid && last, !busy, "busy with final result")
    `FPRA_ASSERT_NOW(a_walk_empty, (state_reg == ST_WAKE) && (count_reg == '0), !fits, "grant from empty queue")

endmodule
`default_nettype wire
